FILE: design/prld_pkg.sv
`default_nettype none

package prld_pkg;

  localparam int RANGE_BITS = 21;
  localparam int LEN_BITS   = 21;
  localparam int PART_BITS  = 13;

  localparam logic [7:0] LEAD_EXT1  = 8'h40;
  localparam logic [7:0] LEAD_EXT2  = 8'h60;
  localparam logic [7:0] LEAD_SHORT = 8'h80;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_ONE,
    PEND_TWO
  } prld_pend_t;

  typedef struct packed {
    logic                start;
    logic                pair;
    logic [LEN_BITS-1:0] len;
  } prld_cmd_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] first;
    logic [RANGE_BITS-1:0] after;
    logic                  last;
  } prld_res_t;

endpackage

`default_nettype wire

FILE: design/prld_queue.sv
`default_nettype none

module prld_queue #(
  parameter int W  = 8,
  parameter int AW = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + AW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: design/prld_front.sv
`default_nettype none

module prld_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  table_byte,
  input  wire logic        start_of_table,
  output logic             cmd_push,
  output prld_pkg::prld_cmd_t cmd
);

  import prld_pkg::*;

  prld_pend_t             pend_r, pend_nxt;
  logic [PART_BITS-1:0]   part_r, part_nxt;
  logic                   pstart_r, pstart_nxt;
  logic                   lead;

  // A start beat always decodes as a lead byte, dropping any open extension.
  assign lead = start_of_table || (pend_r == PEND_NONE);

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      priority if (!lead && pend_r == PEND_TWO) begin
        pend_nxt = PEND_ONE;
      end else if (!lead) begin
        pend_nxt = PEND_NONE;
      end else if (table_byte < LEAD_EXT1 || table_byte >= LEAD_SHORT) begin
        pend_nxt = PEND_NONE;
      end else if (table_byte < LEAD_EXT2) begin
        pend_nxt = PEND_ONE;
      end else begin
        pend_nxt = PEND_TWO;
      end
    end
  end

  always_comb begin
    part_nxt   = part_r;
    pstart_nxt = pstart_r;
    cmd_push   = 1'b0;
    cmd.start  = start_of_table;
    cmd.pair   = 1'b0;
    cmd.len    = '0;
    if (accept) begin
      priority if (!lead && pend_r == PEND_TWO) begin
        part_nxt = {part_r[PART_BITS-9:0], table_byte};
      end else if (!lead) begin
        cmd_push  = 1'b1;
        cmd.start = pstart_r;
        cmd.len   = {part_r, table_byte};
        part_nxt  = '0;
      end else if (table_byte < LEAD_EXT1) begin
        cmd_push = 1'b1;
        cmd.pair = 1'b1;
        cmd.len  = LEN_BITS'(table_byte[5:0]);
      end else if (table_byte >= LEAD_SHORT) begin
        cmd_push = 1'b1;
        cmd.len  = LEN_BITS'(table_byte[6:0]);
      end else begin
        part_nxt   = PART_BITS'(table_byte[4:0]);
        pstart_nxt = start_of_table;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= PEND_NONE;
      part_r   <= '0;
      pstart_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      part_r   <= part_nxt;
      pstart_r <= pstart_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/prld_back.sv
`default_nettype none

module prld_back #(
  parameter int POSITION_BITS = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire prld_pkg::prld_cmd_t cmd,
  output logic                     cmd_pop,
  input  wire logic                res_full,
  output logic                     res_push,
  output prld_pkg::prld_res_t      res
);

  import prld_pkg::*;

  localparam int SW = ((POSITION_BITS > 22) ? POSITION_BITS : 22) + 1;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     phase_r, phase_nxt;
  logic                     go;
  logic                     phase_base;
  logic [SW-1:0]            max_v, pos_base, inc1, inc2, sum1, sum2, a1, a2;

  assign go      = cmd_valid & ~res_full;
  assign cmd_pop = go;
  assign max_v   = SW'({POSITION_BITS{1'b1}});

  always_comb begin
    pos_base   = cmd.start ? '0 : SW'(pos_r);
    phase_base = cmd.start ? 1'b0 : phase_r;
    inc1       = cmd.pair ? SW'(cmd.len[5:3]) + SW'(1) : SW'(cmd.len) + SW'(1);
    sum1       = pos_base + inc1;
    a1         = (sum1 > max_v) ? max_v : sum1;
    inc2       = SW'(cmd.len[2:0]) + SW'(1);
    sum2       = a1 + inc2;
    a2         = (sum2 > max_v) ? max_v : sum2;
  end

  always_comb begin
    res.last  = 1'b1;
    res.first = pos_base[RANGE_BITS-1:0];
    res.after = a1[RANGE_BITS-1:0];
    res_push  = 1'b0;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    if (go) begin
      if (cmd.pair) begin
        // Exactly one of the two packed runs lies inside the set.
        res_push  = 1'b1;
        res.first = phase_base ? pos_base[RANGE_BITS-1:0] : a1[RANGE_BITS-1:0];
        res.after = phase_base ? a1[RANGE_BITS-1:0] : a2[RANGE_BITS-1:0];
        pos_nxt   = a2[POSITION_BITS-1:0];
        phase_nxt = phase_base;
      end else begin
        res_push  = phase_base;
        pos_nxt   = a1[POSITION_BITS-1:0];
        phase_nxt = ~phase_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/property_run_length_decoder.sv
`default_nettype none

// Decodes a run-length coded property table, one byte per push, into half-open
// code point intervals for the runs inside the set. The block sustains one byte
// per cycle while the command queue is not full: a front decoder collects
// extension bytes and turns each completed lead into a run command, a two-entry
// command queue decouples it from the back end, and the back end advances the
// saturating position over one command per cycle while the result queue has
// room, with at most two chained add-and-clamp steps. An interval passes from the
// command queue through the back end into the result queue, from which it shows
// on the result ports. Each byte yields at most one interval, so the result queue
// only stalls the input when results are not popped.
module property_run_length_decoder #(
  parameter int POSITION_BITS = 21
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_table_byte,
  input  wire logic        in_start_of_table,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [20:0]      out_range_first,
  output logic [20:0]      out_range_after,
  output logic             out_last_of_run
);

  import prld_pkg::*;

  logic      in_accept;
  logic      cmd_push;
  prld_cmd_t cmd_in;
  prld_cmd_t cmd_out;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_push;
  logic      res_full;
  prld_res_t res_in;
  prld_res_t res_out;

  assign in_accept = in_push & ~in_full;

  prld_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .table_byte     (in_table_byte),
    .start_of_table (in_start_of_table),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  prld_queue #(
    .W  ($bits(prld_cmd_t)),
    .AW (1)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  prld_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  prld_queue #(
    .W  ($bits(prld_res_t)),
    .AW (1)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_range_first = res_out.first;
  assign out_range_after = res_out.after;
  assign out_last_of_run = res_out.last;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_range_first <= out_range_after)
    else $error("interval end precedes its start");

  a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !cmd_empty)
    else $error("input stalled with no command waiting");

endmodule

`default_nettype wire

FILE: verif/prld_range_checker.sv
module prld_range_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_table_byte,
  input  logic        in_start_of_table,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [20:0] out_range_first,
  input  logic [20:0] out_range_after,
  input  logic        out_last_of_run,
  input  logic        end_check,
  output int          ranges_waiting,
  output int          fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import prld_pkg::*;

  localparam logic [22:0] POS_LIMIT = 23'h1FFFFF;

  logic [20:0] position;
  logic        in_set;
  prld_pend_t  ext_pending;
  logic [20:0] ext_high;
  prld_res_t   byte_ranges[$];
  prld_res_t   expected_ranges[$];
  int          errors;
  bit          end_done;

  task automatic clear_table();
    position    = '0;
    in_set      = 1'b0;
    ext_pending = PEND_NONE;
    ext_high    = '0;
  endtask

  // Covers one run of coded + 1 code points, clamped at the top of the range.
  task automatic cover_run(input logic [20:0] coded);
    logic [22:0] run_end;
    prld_res_t   rng;
    run_end = {2'b00, position} + {2'b00, coded} + 23'd1;
    if (run_end > POS_LIMIT) run_end = POS_LIMIT;
    if (in_set) begin
      rng.first = position;
      rng.after = run_end[20:0];
      rng.last  = 1'b0;
      byte_ranges.push_back(rng);
    end
    position = run_end[20:0];
    in_set   = !in_set;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic restart);
    prld_res_t rng;
    if (restart) clear_table();
    byte_ranges.delete();
    case (ext_pending)
      PEND_TWO: begin
        ext_high    = {ext_high[12:0], b};
        ext_pending = PEND_ONE;
      end
      PEND_ONE: begin
        cover_run({ext_high[12:0], b});
        ext_pending = PEND_NONE;
        ext_high    = '0;
      end
      default: begin
        if (b < LEAD_EXT1) begin
          cover_run(21'(b[5:3]));
          cover_run(21'(b[2:0]));
        end else if (b >= LEAD_SHORT) begin
          cover_run(21'(b - LEAD_SHORT));
        end else if (b < LEAD_EXT2) begin
          ext_high    = 21'(b - LEAD_EXT1);
          ext_pending = PEND_ONE;
        end else begin
          ext_high    = 21'(b - LEAD_EXT2);
          ext_pending = PEND_TWO;
        end
      end
    endcase
    for (int i = 0; i < byte_ranges.size(); i++) begin
      rng      = byte_ranges[i];
      rng.last = (i == byte_ranges.size() - 1);
      expected_ranges.push_back(rng);
    end
  endtask

  task automatic compare_range();
    prld_res_t want;
    if (expected_ranges.size() == 0) begin
      $display("%0t: unexpected range, expected none, got [%0d, %0d) last %0b", $time,
               out_range_first, out_range_after, out_last_of_run);
      errors++;
    end else begin
      want = expected_ranges.pop_front();
      if (out_range_first !== want.first) begin
        $display("%0t: range_first mismatch, expected %0d, got %0d", $time,
                 want.first, out_range_first);
        errors++;
      end
      if (out_range_after !== want.after) begin
        $display("%0t: range_after mismatch, expected %0d, got %0d", $time,
                 want.after, out_range_after);
        errors++;
      end
      if (out_last_of_run !== want.last) begin
        $display("%0t: last_of_run mismatch, expected %0b, got %0b", $time,
                 want.last, out_last_of_run);
        errors++;
      end
    end
  endtask

  initial begin
    clear_table();
    errors   = 0;
    end_done = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      expected_ranges.delete();
    end else begin
      if (in_push && !in_full) decode_byte(in_table_byte, in_start_of_table);
      if (out_pop && !out_empty) compare_range();
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (expected_ranges.size() != 0) begin
          $display("%0t: %0d expected ranges never arrived, expected 0 left, got %0d",
                   $time, expected_ranges.size(), expected_ranges.size());
          errors += expected_ranges.size();
        end
      end
    end
    ranges_waiting <= expected_ranges.size();
    fail_count     <= errors;
  end

endmodule

FILE: verif/property_run_length_decoder_tb.sv
module property_run_length_decoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import prld_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_BYTES    = 510;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_table_byte;
  logic        in_start_of_table;
  logic        out_empty;
  logic        out_pop;
  logic [20:0] out_range_first;
  logic [20:0] out_range_after;
  logic        out_last_of_run;
  logic        end_check;
  int          ranges_waiting;
  int          fail_count;

  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  int bytes_sent;
  int cycles;

  property_run_length_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_table_byte     (in_table_byte),
    .in_start_of_table (in_start_of_table),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_range_first   (out_range_first),
    .out_range_after   (out_range_after),
    .out_last_of_run   (out_last_of_run)
  );

  prld_range_checker range_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_table_byte     (in_table_byte),
    .in_start_of_table (in_start_of_table),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_range_first   (out_range_first),
    .out_range_after   (out_range_after),
    .out_last_of_run   (out_last_of_run),
    .end_check         (end_check),
    .ranges_waiting    (ranges_waiting),
    .fail_count        (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // The receiver; a hold-off request keeps pop low for a long stretch.
  initial begin
    out_pop <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push           <= 1'b1;
    in_table_byte     <= b;
    in_start_of_table <= restart;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  // One run in a random form; a small share breaks off a long length with a new table.
  task automatic send_run(input logic restart);
    int         pick;
    logic [7:0] lead;
    pick = $urandom_range(99);
    if (pick < 35) begin
      push_byte(8'($urandom_range(8'h3F)), restart);
    end else if (pick < 65) begin
      push_byte(8'($urandom_range(8'hFF, 8'h80)), restart);
    end else if (pick < 82) begin
      push_byte(8'($urandom_range(8'h5F, 8'h40)), restart);
      push_byte(8'($urandom), 1'b0);
    end else if (pick < 94) begin
      lead = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h7F, 8'h60)) : LEAD_EXT2;
      push_byte(lead, restart);
      push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b0);
    end else begin
      push_byte(8'($urandom_range(8'h7F, 8'h40)), restart);
      push_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (ranges_waiting != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
    int stop;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop = bytes_sent + PHASE_BYTES;
    send_run(1'b1);
    while (bytes_sent < stop) begin
      if (with_hold && bytes_sent >= stop - PHASE_BYTES / 2) begin
        rx_hold_req = 1'b1;
        with_hold   = 1'b0;
      end
      send_run($urandom_range(24) == 0);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_push           <= 1'b0;
    in_table_byte     <= '0;
    in_start_of_table <= 1'b0;
    end_check         <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b0;
    bytes_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 35;
    rx_idle_pct = 65;
    push_byte(8'h00, 1'b1);
    push_byte(8'h3F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h60, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'h60, 1'b1);
    push_byte(8'h45, 1'b0);
    push_byte(8'h85, 1'b1);
    push_byte(8'h6A, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hC3, 1'b0);
    wait_drained();

    run_phase(35, 65, 1'b0);
    wait_drained();
    run_phase(65, 35, 1'b0);
    wait_drained();
    run_phase(0, 0, 1'b1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/prld_pkg.sv
design/prld_queue.sv
design/prld_front.sv
design/prld_back.sv
design/property_run_length_decoder.sv
verif/prld_range_checker.sv
verif/property_run_length_decoder_tb.sv
